@@ rtl/windowed_trend_convergence_detector_defines.svh @@
// Assertion macros shared by the trend detector RTL
`ifndef WINDOWED_TREND_CONVERGENCE_DETECTOR_DEFINES_SVH
`define WINDOWED_TREND_CONVERGENCE_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define WTCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wtcd_pkg.sv @@
// Shared constants, types and helper functions of the trend detector
package wtcd_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 2);
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = DATA_W + ADDR_W;
    localparam int SQ_W       = 2 * DATA_W + ADDR_W;
    // covers (|residual| << FRAC_BITS), the widest intermediate
    localparam int WIDE_W     = 3 * DATA_W + 3 * ADDR_W + FRAC_BITS + 4;
    localparam int MUL_DIG    = 8;
    localparam int MUL_B_W    = ((SUM_W + MUL_DIG - 1) / MUL_DIG) * MUL_DIG;
    localparam int MUL_STEPS  = MUL_B_W / MUL_DIG;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W  = $clog2(WIDE_W);
    localparam int SLOPE_W    = 32;
    localparam int PRED_W     = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR  = 2'd2;

    localparam logic [WIN_W-1:0]  WINDOW_RST = 7'd10;
    localparam logic [DATA_W-1:0] LIMIT_RST  = 32'd655;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_XX, S_XY, S_ACC, S_CHK, S_OP, S_WAIT, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NSXX, OP_SXSX, OP_NSXY, OP_SXSY, OP_NUMQ, OP_DENQ, OP_DIVQ,
        OP_NT, OP_PA, OP_PB, OP_E, OP_DIVP, OP_C, OP_DIVE
    } t_op;

    typedef struct packed {
        logic               start;
        logic [WIDE_W-1:0]  a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] den;
    } t_div_req;

    function automatic logic [SLOPE_W-1:0] sat_q(input logic [WIDE_W-1:0] mag,
                                                 input logic neg);
        logic [WIDE_W-1:0]  lim;
        logic [SLOPE_W-1:0] res;
        lim = WIDE_W'(1) << (SLOPE_W - 1);
        if (neg) begin
            res = (mag >= lim) ? lim[SLOPE_W-1:0] : (~mag[SLOPE_W-1:0] + SLOPE_W'(1));
        end else begin
            res = (mag >= lim) ? {1'b0, {(SLOPE_W-1){1'b1}}} : mag[SLOPE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [PRED_W-1:0] sat_p(input logic [WIDE_W-1:0] mag,
                                                input logic neg);
        logic [WIDE_W-1:0] lim;
        logic [PRED_W-1:0] res;
        lim = WIDE_W'(1) << (PRED_W - 1);
        if (neg) begin
            res = (mag >= lim) ? lim[PRED_W-1:0] : (~mag[PRED_W-1:0] + PRED_W'(1));
        end else begin
            res = (mag >= lim) ? {1'b0, {(PRED_W-1){1'b1}}} : mag[PRED_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/wtcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module wtcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/wtcd_mul.sv @@
// Shared wide multiplier: one 8-bit digit of the short operand per cycle
module wtcd_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wtcd_pkg::t_mul_req            i_req,
    output logic                          o_done,
    output logic [wtcd_pkg::WIDE_W-1:0]   o_prod
);

    logic [wtcd_pkg::WIDE_W-1:0]                  r_acc;
    logic [wtcd_pkg::WIDE_W-1:0]                  r_a;
    logic [wtcd_pkg::MUL_B_W-1:0]                 r_b;
    logic [wtcd_pkg::MUL_CNT_W-1:0]               r_cnt;
    logic                                         r_busy;
    logic                                         r_done;
    logic [wtcd_pkg::WIDE_W+wtcd_pkg::MUL_DIG-1:0] w_part;

    assign w_part = r_a * r_b[wtcd_pkg::MUL_DIG-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == wtcd_pkg::MUL_CNT_W'(wtcd_pkg::MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // products stay below 2^WIDE_W, so modular truncation is exact
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_part[wtcd_pkg::WIDE_W-1:0];
            r_a   <= r_a << wtcd_pkg::MUL_DIG;
            r_b   <= r_b >> wtcd_pkg::MUL_DIG;
            r_cnt <= r_cnt + wtcd_pkg::MUL_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/wtcd_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating
module wtcd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wtcd_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [wtcd_pkg::WIDE_W-1:0] o_quot
);

    logic [wtcd_pkg::WIDE_W-1:0]    r_rem;
    logic [wtcd_pkg::WIDE_W-1:0]    r_num;
    logic [wtcd_pkg::WIDE_W-1:0]    r_den;
    logic [wtcd_pkg::WIDE_W-1:0]    r_quo;
    logic [wtcd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [wtcd_pkg::WIDE_W:0]      w_sh;
    logic [wtcd_pkg::WIDE_W:0]      w_sub;
    logic                           w_ge;

    assign w_sh  = {r_rem, r_num[wtcd_pkg::WIDE_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == wtcd_pkg::DIV_CNT_W'(wtcd_pkg::WIDE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[wtcd_pkg::WIDE_W-1:0] : w_sh[wtcd_pkg::WIDE_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[wtcd_pkg::WIDE_W-2:0], w_ge};
            r_cnt <= r_cnt + wtcd_pkg::DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/windowed_trend_convergence_detector.sv @@
// Top level: sample ring, window walk and fit sequencer of the trend detector
//
// Input channel i_valid/o_ready carries one (iteration, sample_value) transaction.
// Output channel o_valid/i_ready returns exactly one result per input transaction.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered, no read-back;
// index 0 window_size, 1 slope_limit, 2 error_limit. Write them only while idle.
// Samples go into one 64-bit wide ring RAM. The fit walks the last n entries,
// each through S_RD, S_XX, S_XY and S_ACC (RAM read, then one 32x32
// multiplier used twice). The closed-form fit then runs up to eleven
// multiplies on a shared digit-serial unit and up to three divisions on a
// bit-serial divider. With too few samples the walk and the fit are skipped
// and a result without fit is formed in S_FIN.
// One transaction is in flight at a time; the next one
// is accepted as soon as the previous result sits in the output register.
// Reset clears the write pointer, sample count, running maximum and restores
// the register defaults; ring contents are never read before written.
// If the receiver stalls, the result waits in the output register and the
// following transaction is computed, then held until the register frees.
`include "windowed_trend_convergence_detector_defines.svh"

module windowed_trend_convergence_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wtcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wtcd_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wtcd_pkg::DATA_W-1:0]         i_iteration,
    input  logic [wtcd_pkg::DATA_W-1:0]         i_sample_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_fit_valid,
    output logic                                o_converged,
    output logic signed [wtcd_pkg::SLOPE_W-1:0] o_norm_slope,
    output logic signed [wtcd_pkg::PRED_W-1:0]  o_predicted_value,
    output logic signed [wtcd_pkg::SLOPE_W-1:0] o_rel_error
);

    wtcd_pkg::t_state r_state, n_state;
    wtcd_pkg::t_op    r_op, w_op_next;

    logic [wtcd_pkg::WIN_W-1:0]    r_win;
    logic [wtcd_pkg::DATA_W-1:0]   r_slim, r_elim;
    logic [wtcd_pkg::ADDR_W-1:0]   r_wptr, r_last, r_k, w_idx;
    logic [wtcd_pkg::CNT_W-1:0]    r_count, r_n, w_n, w_cnt_new;
    logic [wtcd_pkg::DATA_W-1:0]   r_gmax, r_maxit, r_val;
    logic [wtcd_pkg::SUM_W-1:0]    r_sx, r_sy;
    logic [wtcd_pkg::SQ_W-1:0]     r_sxx, r_sxy;
    logic [2*wtcd_pkg::DATA_W-1:0] r_prod, w_wprod, w_rdata;
    logic [wtcd_pkg::DATA_W-1:0]   w_x, w_y, w_my;
    logic [wtcd_pkg::WIDE_W-1:0]   r_t1, r_t2, r_den, r_nmag, r_pmag, r_e;
    logic [wtcd_pkg::WIDE_W-1:0]   r_q, r_pq, r_eq, w_mres, w_dres;
    logic [wtcd_pkg::WIDE_W-1:0]   w_diff, w_rdiff;
    logic [wtcd_pkg::MUL_B_W-1:0]  r_tt;
    logic                          r_nneg, r_pneg, r_rneg, r_zero;
    logic                          w_in_acc, w_few, w_last, w_is_div, w_done, w_load;
    logic                          w_mul_done, w_div_done;
    logic                          r_ovalid, r_o_fit, r_o_conv;
    logic [wtcd_pkg::SLOPE_W-1:0]  r_o_slope, r_o_err;
    logic [wtcd_pkg::PRED_W-1:0]   r_o_pred;
    wtcd_pkg::t_mul_req            w_mul_req;
    wtcd_pkg::t_div_req            w_div_req;

    wtcd_ram #(
        .WIDTH (2 * wtcd_pkg::DATA_W),
        .DEPTH (wtcd_pkg::MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wptr),
        .i_wdata ({i_iteration, i_sample_value}),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    wtcd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mres)
    );

    wtcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_dres)
    );

    assign o_ready  = (r_state == wtcd_pkg::S_IDLE);
    assign w_in_acc = i_valid && o_ready;

    // effective window, clamped to [2, MAX_WINDOW]
    always_comb begin
        if (r_win < wtcd_pkg::WIN_W'(2)) begin
            w_n = wtcd_pkg::CNT_W'(2);
        end else if (32'(r_win) > 32'(wtcd_pkg::MAX_WINDOW)) begin
            w_n = wtcd_pkg::CNT_W'(wtcd_pkg::MAX_WINDOW);
        end else begin
            w_n = wtcd_pkg::CNT_W'(r_win);
        end
    end

    assign w_cnt_new = (r_count < wtcd_pkg::CNT_W'(wtcd_pkg::MAX_WINDOW + 1)) ?
                       r_count + wtcd_pkg::CNT_W'(1) : r_count;
    assign w_few     = (w_cnt_new <= w_n);

    // k-th most recent entry, wrapping around the ring
    assign w_idx = (r_last >= r_k) ? r_last - r_k :
                   wtcd_pkg::ADDR_W'(32'(r_last) + 32'(wtcd_pkg::MAX_WINDOW) - 32'(r_k));
    assign w_last = (wtcd_pkg::CNT_W'(r_k) == r_n - wtcd_pkg::CNT_W'(1));

    assign w_x     = w_rdata[2*wtcd_pkg::DATA_W-1:wtcd_pkg::DATA_W];
    assign w_y     = w_rdata[wtcd_pkg::DATA_W-1:0];
    assign w_my    = (r_state == wtcd_pkg::S_XX) ? w_x : w_y;
    assign w_wprod = w_x * w_my;

    assign w_is_div = (r_op == wtcd_pkg::OP_DIVQ) || (r_op == wtcd_pkg::OP_DIVP) ||
                      (r_op == wtcd_pkg::OP_DIVE);
    assign w_done   = w_is_div ? w_div_done : w_mul_done;
    assign w_diff   = (r_t1 >= w_mres) ? r_t1 - w_mres : w_mres - r_t1;
    assign w_rdiff  = (w_mres >= r_pmag) ? w_mres - r_pmag : r_pmag - w_mres;
    assign w_load   = (r_state == wtcd_pkg::S_FIN) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_mul_req = '0;
        w_div_req = '0;
        unique case (r_op)
            wtcd_pkg::OP_NSXX: w_op_next = wtcd_pkg::OP_SXSX;
            wtcd_pkg::OP_SXSX: w_op_next = wtcd_pkg::OP_NSXY;
            wtcd_pkg::OP_NSXY: w_op_next = wtcd_pkg::OP_SXSY;
            wtcd_pkg::OP_SXSY: w_op_next = wtcd_pkg::OP_NUMQ;
            wtcd_pkg::OP_NUMQ: w_op_next = wtcd_pkg::OP_DENQ;
            wtcd_pkg::OP_DENQ: w_op_next = wtcd_pkg::OP_DIVQ;
            wtcd_pkg::OP_DIVQ: w_op_next = wtcd_pkg::OP_NT;
            wtcd_pkg::OP_NT:   w_op_next = wtcd_pkg::OP_PA;
            wtcd_pkg::OP_PA:   w_op_next = wtcd_pkg::OP_PB;
            wtcd_pkg::OP_PB:   w_op_next = wtcd_pkg::OP_E;
            wtcd_pkg::OP_E:    w_op_next = wtcd_pkg::OP_DIVP;
            wtcd_pkg::OP_DIVP: w_op_next = wtcd_pkg::OP_C;
            wtcd_pkg::OP_C:    w_op_next = wtcd_pkg::OP_DIVE;
            default:           w_op_next = wtcd_pkg::OP_DIVE;
        endcase
        unique case (r_state)
            wtcd_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = w_few ? wtcd_pkg::S_FIN : wtcd_pkg::S_RD;
                end
            end
            wtcd_pkg::S_RD:  n_state = wtcd_pkg::S_XX;
            wtcd_pkg::S_XX:  n_state = wtcd_pkg::S_XY;
            wtcd_pkg::S_XY:  n_state = wtcd_pkg::S_ACC;
            wtcd_pkg::S_ACC: n_state = w_last ? wtcd_pkg::S_CHK : wtcd_pkg::S_RD;
            wtcd_pkg::S_CHK: begin
                n_state = (r_maxit == '0 || r_gmax == '0) ? wtcd_pkg::S_FIN : wtcd_pkg::S_OP;
            end
            wtcd_pkg::S_OP: begin
                n_state = wtcd_pkg::S_WAIT;
                unique case (r_op)
                    wtcd_pkg::OP_NSXX: begin
                        w_mul_req = '{1'b1, wtcd_pkg::WIDE_W'(r_sxx), wtcd_pkg::MUL_B_W'(r_n)};
                    end
                    wtcd_pkg::OP_SXSX: begin
                        w_mul_req = '{1'b1, wtcd_pkg::WIDE_W'(r_sx), wtcd_pkg::MUL_B_W'(r_sx)};
                    end
                    wtcd_pkg::OP_NSXY: begin
                        w_mul_req = '{1'b1, wtcd_pkg::WIDE_W'(r_sxy), wtcd_pkg::MUL_B_W'(r_n)};
                    end
                    wtcd_pkg::OP_SXSY: begin
                        w_mul_req = '{1'b1, wtcd_pkg::WIDE_W'(r_sy), wtcd_pkg::MUL_B_W'(r_sx)};
                    end
                    wtcd_pkg::OP_NUMQ: begin
                        w_mul_req = '{1'b1, r_nmag, wtcd_pkg::MUL_B_W'(r_maxit)};
                    end
                    wtcd_pkg::OP_DENQ: begin
                        w_mul_req = '{1'b1, r_den, wtcd_pkg::MUL_B_W'(r_gmax)};
                    end
                    wtcd_pkg::OP_NT: begin
                        w_mul_req = '{1'b1, wtcd_pkg::WIDE_W'(r_maxit) + wtcd_pkg::WIDE_W'(1),
                                      wtcd_pkg::MUL_B_W'(r_n)};
                    end
                    wtcd_pkg::OP_PA: begin
                        w_mul_req = '{1'b1, r_den, wtcd_pkg::MUL_B_W'(r_sy)};
                    end
                    wtcd_pkg::OP_PB: w_mul_req = '{1'b1, r_nmag, r_tt};
                    wtcd_pkg::OP_E: begin
                        w_mul_req = '{1'b1, r_den, wtcd_pkg::MUL_B_W'(r_n)};
                    end
                    wtcd_pkg::OP_C: begin
                        w_mul_req = '{1'b1, r_e, wtcd_pkg::MUL_B_W'(r_val)};
                    end
                    wtcd_pkg::OP_DIVP: w_div_req = '{1'b1, r_pmag, r_e};
                    default:           w_div_req = '{1'b1, r_t1, r_t2};
                endcase
            end
            wtcd_pkg::S_WAIT: begin
                if (w_done) begin
                    unique case (r_op)
                        wtcd_pkg::OP_SXSX: begin
                            n_state = (r_t1 == w_mres) ? wtcd_pkg::S_FIN : wtcd_pkg::S_OP;
                        end
                        wtcd_pkg::OP_DIVP: begin
                            n_state = (r_val == '0) ? wtcd_pkg::S_FIN : wtcd_pkg::S_OP;
                        end
                        wtcd_pkg::OP_DIVE: n_state = wtcd_pkg::S_FIN;
                        default:           n_state = wtcd_pkg::S_OP;
                    endcase
                end
            end
            wtcd_pkg::S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_state = wtcd_pkg::S_IDLE;
                end
            end
            default: n_state = wtcd_pkg::S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= wtcd_pkg::WINDOW_RST;
            r_slim   <= wtcd_pkg::LIMIT_RST;
            r_elim   <= wtcd_pkg::LIMIT_RST;
            r_wptr   <= '0;
            r_count  <= '0;
            r_gmax   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wtcd_pkg::CFG_WINDOW: r_win  <= i_cfg_data[wtcd_pkg::WIN_W-1:0];
                    wtcd_pkg::CFG_SLOPE:  r_slim <= i_cfg_data;
                    wtcd_pkg::CFG_ERROR:  r_elim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_wptr  <= (r_wptr == wtcd_pkg::ADDR_W'(wtcd_pkg::MAX_WINDOW - 1)) ?
                           '0 : r_wptr + wtcd_pkg::ADDR_W'(1);
                r_count <= w_cnt_new;
                if (i_sample_value > r_gmax) begin
                    r_gmax <= i_sample_value;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_val   <= i_sample_value;
            r_last  <= r_wptr;
            r_n     <= w_n;
            r_k     <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_maxit <= '0;
            r_zero  <= w_few;
            r_eq    <= '0;
            r_rneg  <= 1'b0;
        end
        case (r_state)
            wtcd_pkg::S_XX: begin
                r_sx   <= r_sx + wtcd_pkg::SUM_W'(w_x);
                r_sy   <= r_sy + wtcd_pkg::SUM_W'(w_y);
                r_prod <= w_wprod;
                if (w_x > r_maxit) begin
                    r_maxit <= w_x;
                end
            end
            wtcd_pkg::S_XY: begin
                r_sxx  <= r_sxx + wtcd_pkg::SQ_W'(r_prod);
                r_prod <= w_wprod;
            end
            wtcd_pkg::S_ACC: begin
                r_sxy <= r_sxy + wtcd_pkg::SQ_W'(r_prod);
                r_k   <= r_k + wtcd_pkg::ADDR_W'(1);
            end
            wtcd_pkg::S_CHK: begin
                r_zero <= (r_maxit == '0 || r_gmax == '0);
                r_op   <= wtcd_pkg::OP_NSXX;
            end
            wtcd_pkg::S_WAIT: begin
                if (w_done) begin
                    r_op <= w_op_next;
                    case (r_op)
                        wtcd_pkg::OP_NSXX: r_t1 <= w_mres;
                        wtcd_pkg::OP_SXSX: begin
                            r_den  <= r_t1 - w_mres;
                            r_zero <= (r_t1 == w_mres);
                        end
                        wtcd_pkg::OP_NSXY: r_t1 <= w_mres;
                        wtcd_pkg::OP_SXSY: begin
                            r_nneg <= (r_t1 < w_mres);
                            r_nmag <= w_diff;
                        end
                        wtcd_pkg::OP_NUMQ: r_t1 <= w_mres << wtcd_pkg::FRAC_BITS;
                        wtcd_pkg::OP_DENQ: r_t2 <= w_mres;
                        wtcd_pkg::OP_DIVQ: r_q  <= w_dres;
                        wtcd_pkg::OP_NT: begin
                            r_tt <= wtcd_pkg::MUL_B_W'(w_mres - wtcd_pkg::WIDE_W'(r_sx));
                        end
                        wtcd_pkg::OP_PA: r_t1 <= w_mres;
                        wtcd_pkg::OP_PB: begin
                            if (!r_nneg) begin
                                r_pmag <= r_t1 + w_mres;
                                r_pneg <= 1'b0;
                            end else begin
                                r_pmag <= w_diff;
                                r_pneg <= (r_t1 < w_mres);
                            end
                        end
                        wtcd_pkg::OP_E:    r_e  <= w_mres;
                        wtcd_pkg::OP_DIVP: r_pq <= w_dres;
                        wtcd_pkg::OP_C: begin
                            // w_mres is current value times n*den
                            r_t2 <= w_mres;
                            if (r_pneg) begin
                                r_t1   <= (w_mres + r_pmag) << wtcd_pkg::FRAC_BITS;
                                r_rneg <= 1'b0;
                            end else begin
                                r_t1   <= w_rdiff << wtcd_pkg::FRAC_BITS;
                                r_rneg <= (w_mres < r_pmag);
                            end
                        end
                        default: r_eq <= w_dres;
                    endcase
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_o_fit   <= !r_zero;
            r_o_conv  <= !r_zero && (r_q < wtcd_pkg::WIDE_W'(r_slim)) &&
                         (r_eq < wtcd_pkg::WIDE_W'(r_elim));
            r_o_slope <= r_zero ? '0 : wtcd_pkg::sat_q(r_q, r_nneg);
            r_o_pred  <= r_zero ? '0 : wtcd_pkg::sat_p(r_pq, r_pneg);
            r_o_err   <= r_zero ? '0 : wtcd_pkg::sat_q(r_eq, r_rneg);
        end
    end

    assign o_valid           = r_ovalid;
    assign o_fit_valid       = r_o_fit;
    assign o_converged       = r_o_conv;
    assign o_norm_slope      = r_o_slope;
    assign o_predicted_value = r_o_pred;
    assign o_rel_error       = r_o_err;

    `WTCD_ASSERT_NOW(a_nofit_zero, o_valid && !o_fit_valid, !o_converged && o_norm_slope == '0 && o_predicted_value == '0 && o_rel_error == '0, "result without fit carries nonzero fields")
    `WTCD_ASSERT_NOW(a_walk_range, r_state == wtcd_pkg::S_XX, wtcd_pkg::CNT_W'(r_k) < r_n, "window walk ran past n")
    `WTCD_ASSERT_NOW(a_unit_done, w_mul_done || w_div_done, r_state == wtcd_pkg::S_WAIT, "arithmetic unit finished outside wait state")
    `WTCD_ASSERT_NEXT(a_accept_busy, w_in_acc, r_state != wtcd_pkg::S_IDLE, "accepted transaction did not start")

endmodule
